[sv/c8alu_pkg.sv]
package c8alu_pkg;

   localparam int DATA_W = 8;
   localparam int NIB_W  = 4;
   localparam int CMD_W  = 5;
   localparam int BSEL_W = 3;

   localparam logic [NIB_W-1:0]  NIB_MASK  = 4'hF;
   localparam logic [DATA_W-1:0] BYTE_MASK = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD  = 5'd0,
      CMD_ADC  = 5'd1,
      CMD_SUB  = 5'd2,
      CMD_SBC  = 5'd3,
      CMD_AND  = 5'd4,
      CMD_OR   = 5'd5,
      CMD_XOR  = 5'd6,
      CMD_CP   = 5'd7,
      CMD_INC  = 5'd8,
      CMD_DEC  = 5'd9,
      CMD_CCF  = 5'd10,
      CMD_SCF  = 5'd11,
      CMD_CPL  = 5'd12,
      CMD_RLCA = 5'd13,
      CMD_RRCA = 5'd14,
      CMD_RLA  = 5'd15,
      CMD_RRA  = 5'd16,
      CMD_RLC  = 5'd17,
      CMD_RRC  = 5'd18,
      CMD_RL   = 5'd19,
      CMD_RR   = 5'd20,
      CMD_SLA  = 5'd21,
      CMD_SRA  = 5'd22,
      CMD_SRL  = 5'd23,
      CMD_SWAP = 5'd24,
      CMD_BIT  = 5'd25,
      CMD_RES  = 5'd26,
      CMD_SET  = 5'd27
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] acc_value;
      logic [DATA_W-1:0] operand_value;
      logic [BSEL_W-1:0] bit_select;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              write_back;
      logic              zero_flag;
      logic              subtract_flag;
      logic              half_carry_flag;
      logic              carry_flag;
   } rsp_payload_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

endpackage

[sv/c8alu_chan_if.sv]
interface c8alu_chan_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/cpu8_alu_with_flags.sv]
// 8-bit ALU of an SM83-style CPU with its own Z/N/H/C flag register. It takes one
// operation word per cycle, unless the result side stalls with both registers full,
// and returns one result word per operation, in order. The word is captured in an
// input register, the ALU and flag update run in one pass between that register and
// the result register, and the flag register is written as the word moves on, so
// each word sees the flags left by the one before it. Two words can be held; req
// ready falls only while both registers are full and the result side stalls.
module cpu8_alu_with_flags
   import c8alu_pkg::*;
(
   input logic          clock,
   input logic          reset,
   c8alu_chan_if.sink   req_ch,
   c8alu_chan_if.source rsp_ch
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   flags_type       flags_ff;
   flags_type       flags_in;
   logic            req_fire;
   logic            advance;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;

   assign req_ch.ready   = !in_valid_ff || advance;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   c8alu_core u_core (
      .req_word  (in_data_ff),
      .flags_cur (flags_ff),
      .rsp_word  (out_data_in),
      .flags_nxt (flags_in)
   );

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_ch.payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

[sv/c8alu_core.sv]
module c8alu_core
   import c8alu_pkg::*;
(
   input  req_payload_type req_word,
   input  flags_type       flags_cur,
   output rsp_payload_type rsp_word,
   output flags_type       flags_nxt
);

   logic [DATA_W-1:0]  a;
   logic [DATA_W-1:0]  v;
   logic [DATA_W-1:0]  x;
   logic [DATA_W-1:0]  mask;
   logic               ci;
   logic               k;
   logic [DATA_W:0]    sum9;
   logic [NIB_W:0]     sum5;
   logic [DATA_W:0]    dif9;
   logic [NIB_W:0]     dif5;
   logic [DATA_W-1:0]  r;
   logic               wb;
   logic               zr;
   flags_type          f;

   assign a    = req_word.acc_value;
   assign v    = req_word.operand_value;
   assign ci   = flags_cur.c;
   assign mask = DATA_W'(1) << req_word.bit_select;

   // The adder carry-in is taken from C only by the with-carry forms.
   assign k = ((req_word.cmd == CMD_ADC) || (req_word.cmd == CMD_SBC)) ? ci : 1'b0;

   assign sum9 = {1'b0, a} + {1'b0, v} + {{DATA_W{1'b0}}, k};
   assign sum5 = {1'b0, a[NIB_W-1:0]} + {1'b0, v[NIB_W-1:0]} + {{NIB_W{1'b0}}, k};
   assign dif9 = {1'b0, a} - {1'b0, v} - {{DATA_W{1'b0}}, k};
   assign dif5 = {1'b0, a[NIB_W-1:0]} - {1'b0, v[NIB_W-1:0]} - {{NIB_W{1'b0}}, k};

   // The accumulator rotates act on A, the prefixed forms on the operand.
   assign x = (req_word.cmd <= CMD_RRA) ? a : v;

   always_comb begin
      r  = '0;
      wb = 1'b1;
      zr = 1'b1;
      f  = flags_cur;
      unique case (cmd_type'(req_word.cmd))
         CMD_ADD, CMD_ADC: begin
            r   = sum9[DATA_W-1:0];
            f.n = 1'b0;
            f.h = sum5[NIB_W];
            f.c = sum9[DATA_W];
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            r   = dif9[DATA_W-1:0];
            f.n = 1'b1;
            f.h = dif5[NIB_W];
            f.c = dif9[DATA_W];
            wb  = (req_word.cmd != CMD_CP);
         end
         CMD_AND: begin
            r = a & v;
            f.n = 1'b0; f.h = 1'b1; f.c = 1'b0;
         end
         CMD_OR: begin
            r = a | v;
            f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
         end
         CMD_XOR: begin
            r = a ^ v;
            f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
         end
         CMD_INC: begin
            r   = v + DATA_W'(1);
            f.n = 1'b0;
            f.h = (v[NIB_W-1:0] == NIB_MASK);
         end
         CMD_DEC: begin
            r   = v - DATA_W'(1);
            f.n = 1'b1;
            f.h = (v[NIB_W-1:0] == '0);
         end
         CMD_CCF: begin
            wb = 1'b0; zr = 1'b0;
            f.n = 1'b0; f.h = 1'b0; f.c = ~ci;
         end
         CMD_SCF: begin
            wb = 1'b0; zr = 1'b0;
            f.n = 1'b0; f.h = 1'b0; f.c = 1'b1;
         end
         CMD_CPL: begin
            r  = ~a & BYTE_MASK;
            zr = 1'b0;
            f.n = 1'b1; f.h = 1'b1;
         end
         CMD_RLCA, CMD_RLC: begin
            r   = {x[DATA_W-2:0], x[DATA_W-1]};
            f.c = x[DATA_W-1];
         end
         CMD_RRCA, CMD_RRC: begin
            r   = {x[0], x[DATA_W-1:1]};
            f.c = x[0];
         end
         CMD_RLA, CMD_RL: begin
            r   = {x[DATA_W-2:0], ci};
            f.c = x[DATA_W-1];
         end
         CMD_RRA, CMD_RR: begin
            r   = {ci, x[DATA_W-1:1]};
            f.c = x[0];
         end
         CMD_SLA: begin
            r   = {x[DATA_W-2:0], 1'b0};
            f.c = x[DATA_W-1];
         end
         CMD_SRA: begin
            r   = {x[DATA_W-1], x[DATA_W-1:1]};
            f.c = x[0];
         end
         CMD_SRL: begin
            r   = {1'b0, x[DATA_W-1:1]};
            f.c = x[0];
         end
         CMD_SWAP: begin
            r = {v[NIB_W-1:0], v[DATA_W-1:NIB_W]};
            f.n = 1'b0; f.h = 1'b0; f.c = 1'b0;
         end
         CMD_BIT: begin
            wb = 1'b0; zr = 1'b0;
            f.z = ~v[req_word.bit_select];
            f.n = 1'b0; f.h = 1'b1;
         end
         CMD_RES: begin
            r  = v & ~mask;
            zr = 1'b0;
         end
         CMD_SET: begin
            r  = v | mask;
            zr = 1'b0;
         end
         default: begin
            wb = 1'b0; zr = 1'b0;
         end
      endcase

      // All shifts and rotates clear N and H; the accumulator rotates also clear Z.
      if ((req_word.cmd >= CMD_RLCA) && (req_word.cmd <= CMD_SRL)) begin
         f.n = 1'b0;
         f.h = 1'b0;
         if (req_word.cmd <= CMD_RRA) begin
            zr  = 1'b0;
            f.z = 1'b0;
         end
      end

      if (zr) begin
         f.z = (r == '0);
      end
   end

   assign flags_nxt = f;

   always_comb begin
      rsp_word.result_value    = r;
      rsp_word.write_back      = wb;
      rsp_word.zero_flag       = f.z;
      rsp_word.subtract_flag   = f.n;
      rsp_word.half_carry_flag = f.h;
      rsp_word.carry_flag      = f.c;
   end

endmodule

[sv/c8alu_checker.sv]
module c8alu_checker
   import c8alu_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A result word that waits must not change under the consumer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input backpressure is only allowed while the result side is stalled.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // Compare is the only non-writing operation that sets N and yields a nonzero byte.
   a_nowb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_back && !rsp_data.subtract_flag
         |-> rsp_data.result_value == '0)
      else $error("non-writing operation produced a nonzero byte");

endmodule

bind cpu8_alu_with_flags c8alu_checker u_c8alu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.payload)
);

[sim/cpu8_alu_with_flags_test.sv]
`timescale 1ns / 1ps

module cpu8_alu_with_flags_test;
   import c8alu_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NOP_LO = 5'd28;
   localparam logic [CMD_W-1:0] CMD_NOP_HI = 5'd31;
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;

   c8alu_chan_if #(.payload_type(req_payload_type)) req_ch ();
   c8alu_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   cpu8_alu_with_flags uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   flags_type       model_flags;
   rsp_payload_type expected_results[$];
   int              error_count;
   int              words_sent;
   int              words_checked;
   int              cmd_seen[32];
   bit              req_gaps_on;
   bit              rsp_stalls_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Timeout: %0d result words still outstanding", expected_results.size());
      $display("Test completed with failures");
      $finish;
   end

   // Mirror of the ALU: computes the result word and updates the flag copy.
   function automatic rsp_payload_type compute_alu_result(input req_payload_type w);
      logic [7:0]      a;
      logic [7:0]      v;
      logic [7:0]      x;
      logic [7:0]      r;
      logic [8:0]      wide;
      logic            k;
      logic            z;
      logic            n;
      logic            h;
      logic            c;
      logic            wb;
      logic            z_from_r;
      logic            acc_rotate;
      rsp_payload_type res;
      a = w.acc_value;
      v = w.operand_value;
      z = model_flags.z;
      n = model_flags.n;
      h = model_flags.h;
      c = model_flags.c;
      r = '0;
      wb = 1'b1;
      z_from_r = 1'b1;
      k = 1'b0;
      acc_rotate = (w.cmd >= CMD_RLCA) && (w.cmd <= CMD_RRA);
      x = acc_rotate ? a : v;
      case (w.cmd)
         CMD_ADD, CMD_ADC: begin
            k = (w.cmd == CMD_ADC) ? model_flags.c : 1'b0;
            wide = {1'b0, a} + {1'b0, v} + k;
            r = wide[7:0];
            n = 1'b0;
            h = ({1'b0, a[3:0]} + {1'b0, v[3:0]} + k) > {1'b0, NIB_MASK};
            c = wide[8];
         end
         CMD_SUB, CMD_SBC, CMD_CP: begin
            k = (w.cmd == CMD_SBC) ? model_flags.c : 1'b0;
            wide = {1'b0, a} - {1'b0, v} - k;
            r = wide[7:0];
            n = 1'b1;
            h = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + k);
            c = {1'b0, a} < ({1'b0, v} + k);
            if (w.cmd == CMD_CP) wb = 1'b0;
         end
         CMD_AND: begin
            r = a & v; n = 1'b0; h = 1'b1; c = 1'b0;
         end
         CMD_OR: begin
            r = a | v; n = 1'b0; h = 1'b0; c = 1'b0;
         end
         CMD_XOR: begin
            r = a ^ v; n = 1'b0; h = 1'b0; c = 1'b0;
         end
         CMD_INC: begin
            r = v + 8'd1; n = 1'b0; h = (v[3:0] == NIB_MASK);
         end
         CMD_DEC: begin
            r = v - 8'd1; n = 1'b1; h = (v[3:0] == 4'h0);
         end
         CMD_CCF: begin
            wb = 1'b0; z_from_r = 1'b0; n = 1'b0; h = 1'b0; c = ~model_flags.c;
         end
         CMD_SCF: begin
            wb = 1'b0; z_from_r = 1'b0; n = 1'b0; h = 1'b0; c = 1'b1;
         end
         CMD_CPL: begin
            r = ~a; z_from_r = 1'b0; n = 1'b1; h = 1'b1;
         end
         CMD_RLCA, CMD_RLC: begin
            r = {x[6:0], x[7]}; c = x[7];
         end
         CMD_RRCA, CMD_RRC: begin
            r = {x[0], x[7:1]}; c = x[0];
         end
         CMD_RLA, CMD_RL: begin
            r = {x[6:0], model_flags.c}; c = x[7];
         end
         CMD_RRA, CMD_RR: begin
            r = {model_flags.c, x[7:1]}; c = x[0];
         end
         CMD_SLA: begin
            r = {v[6:0], 1'b0}; c = v[7];
         end
         CMD_SRA: begin
            r = {v[7], v[7:1]}; c = v[0];
         end
         CMD_SRL: begin
            r = {1'b0, v[7:1]}; c = v[0];
         end
         CMD_SWAP: begin
            r = {v[3:0], v[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0;
         end
         CMD_BIT: begin
            wb = 1'b0; z_from_r = 1'b0;
            z = ~v[w.bit_select]; n = 1'b0; h = 1'b1;
         end
         CMD_RES: begin
            r = v & ~(8'd1 << w.bit_select); z_from_r = 1'b0;
         end
         CMD_SET: begin
            r = v | (8'd1 << w.bit_select); z_from_r = 1'b0;
         end
         default: begin
            wb = 1'b0; z_from_r = 1'b0;
         end
      endcase
      // All rotates and shifts clear N and H; the accumulator forms also clear Z.
      if ((w.cmd >= CMD_RLCA) && (w.cmd <= CMD_SRL)) begin
         n = 1'b0;
         h = 1'b0;
         if (acc_rotate) begin
            z_from_r = 1'b0;
            z = 1'b0;
         end
      end
      if (z_from_r) z = (r == 8'h00);
      model_flags.z = z;
      model_flags.n = n;
      model_flags.h = h;
      model_flags.c = c;
      res.result_value = r & BYTE_MASK;
      res.write_back = wb;
      res.zero_flag = z;
      res.subtract_flag = n;
      res.half_carry_flag = h;
      res.carry_flag = c;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 40)
         $display("Mismatch at result word %0d, %s: got %0h, expected %0h",
                  words_checked, what, got, want);
   endtask

   task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [7:0] acc,
                          input logic [7:0] opnd, input logic [2:0] bsel);
      req_payload_type w;
      w.cmd = cmd;
      w.acc_value = acc;
      w.operand_value = opnd;
      w.bit_select = bsel;
      if (req_gaps_on && ($urandom_range(0, 3) == 0)) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_results.push_back(compute_alu_result(w));
      cmd_seen[cmd]++;
      words_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h0F;
         3: return 8'hF0;
         4: return 8'h80;
         5: return 8'h7F;
         6: return 8'h01;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_op();
      logic [CMD_W-1:0] cmd;
      if ($urandom_range(0, 49) == 0)
         cmd = 5'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
      else
         cmd = 5'($urandom_range(CMD_ADD, CMD_SET));
      send_op(cmd, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)));
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_payload_type got;
         rsp_payload_type want;
         got = rsp_ch.payload;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", int'(got), 0);
         end else begin
            want = expected_results.pop_front();
            if (got.result_value !== want.result_value)
               report_mismatch("result_value", int'(got.result_value),
                               int'(want.result_value));
            if (got.write_back !== want.write_back)
               report_mismatch("write_back", int'(got.write_back), int'(want.write_back));
            if (got.zero_flag !== want.zero_flag)
               report_mismatch("zero_flag", int'(got.zero_flag), int'(want.zero_flag));
            if (got.subtract_flag !== want.subtract_flag)
               report_mismatch("subtract_flag", int'(got.subtract_flag),
                               int'(want.subtract_flag));
            if (got.half_carry_flag !== want.half_carry_flag)
               report_mismatch("half_carry_flag", int'(got.half_carry_flag),
                               int'(want.half_carry_flag));
            if (got.carry_flag !== want.carry_flag)
               report_mismatch("carry_flag", int'(got.carry_flag), int'(want.carry_flag));
         end
         words_checked++;
      end
   end

   // The result side stalls in short random bursts while stalls are enabled.
   always begin
      @(posedge clock);
      if (rsp_stalls_on && ($urandom_range(0, 4) == 0)) begin
         rsp_ch.ready <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      rsp_ch.ready <= 1'b1;
   end

   task automatic test_arith_logic();
      send_op(CMD_SCF, 8'h00, 8'h00, 3'd0);
      send_op(CMD_ADC, 8'hFF, 8'h00, 3'd0);
      send_op(CMD_SBC, 8'h00, 8'h00, 3'd0);
      send_op(CMD_ADD, 8'h0F, 8'h01, 3'd0);
      send_op(CMD_SUB, 8'h10, 8'h01, 3'd0);
      send_op(CMD_CP, 8'h80, 8'h80, 3'd0);
      send_op(CMD_AND, 8'hF0, 8'h0F, 3'd0);
      send_op(CMD_OR, 8'h00, 8'h00, 3'd0);
      send_op(CMD_XOR, 8'hFF, 8'hFF, 3'd0);
      send_op(CMD_INC, 8'h00, 8'hFF, 3'd0);
      send_op(CMD_DEC, 8'h00, 8'h00, 3'd0);
   endtask

   task automatic test_flag_ops();
      send_op(CMD_CCF, 8'hFF, 8'hFF, 3'd7);
      send_op(CMD_CPL, 8'h55, 8'h00, 3'd0);
   endtask

   task automatic test_rotates_shifts();
      send_op(CMD_RLCA, 8'h80, 8'h00, 3'd0);
      send_op(CMD_RRCA, 8'h01, 8'h00, 3'd0);
      send_op(CMD_RLA, 8'h00, 8'hFF, 3'd0);
      send_op(CMD_RRA, 8'h00, 8'hFF, 3'd0);
      send_op(CMD_RLC, 8'hFF, 8'h00, 3'd0);
      send_op(CMD_RRC, 8'h00, 8'h01, 3'd0);
      send_op(CMD_RL, 8'h00, 8'h80, 3'd0);
      send_op(CMD_RR, 8'h00, 8'h01, 3'd0);
      send_op(CMD_SLA, 8'h00, 8'h80, 3'd0);
      send_op(CMD_SRA, 8'h00, 8'h81, 3'd0);
      send_op(CMD_SRL, 8'h00, 8'h01, 3'd0);
      send_op(CMD_SWAP, 8'h00, 8'hF0, 3'd0);
   endtask

   task automatic test_bit_ops();
      send_op(CMD_BIT, 8'h00, 8'h80, 3'd7);
      send_op(CMD_BIT, 8'hFF, 8'h7F, 3'd7);
      send_op(CMD_RES, 8'h00, 8'hFF, 3'd0);
      send_op(CMD_SET, 8'h00, 8'h00, 3'd7);
   endtask

   task automatic test_unused_codes();
      send_op(CMD_NOP_LO, 8'hFF, 8'hFF, 3'd7);
      send_op(CMD_NOP_HI, 8'h00, 8'h00, 3'd0);
   endtask

   // Multi-byte add and subtract chains, and carry set-up followed by rotates,
   // so the carry fed between words matters.
   task automatic test_carry_chains();
      int               chain;
      int               i;
      logic [CMD_W-1:0] first_cmd;
      for (chain = 0; chain < 50; chain++) begin
         first_cmd = $urandom_range(0, 1) ? CMD_ADD : CMD_SUB;
         send_op(first_cmd, pick_byte(), pick_byte(), 3'd0);
         for (i = 0; i < 3; i++)
            send_op((first_cmd == CMD_ADD) ? CMD_ADC : CMD_SBC,
                    pick_byte(), pick_byte(), 3'd0);
         send_op($urandom_range(0, 1) ? CMD_SCF : CMD_CCF, pick_byte(), pick_byte(), 3'd0);
         send_op(5'($urandom_range(CMD_RLA, CMD_RRA)), pick_byte(), pick_byte(), 3'd0);
      end
   endtask

   task automatic test_random_mix(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            req_gaps_on = ($urandom_range(0, 2) != 0);
            rsp_stalls_on = ($urandom_range(0, 2) != 0);
         end
         send_random_op();
      end
   endtask

   task automatic test_drain_pause();
      int i;
      for (i = 0; i < 40; i++) send_random_op();
      wait_for_drain();
      for (i = 0; i < 40; i++) send_random_op();
   endtask

   task automatic test_full_rate(input int count);
      int i;
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      for (i = 0; i < count; i++) send_random_op();
   endtask

   initial begin
      int n;
      int codes_hit;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      rsp_ch.ready <= 1'b0;
      model_flags = '0;
      error_count = 0;
      words_sent = 0;
      words_checked = 0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      for (n = 0; n < 32; n++) cmd_seen[n] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_arith_logic();
      test_flag_ops();
      test_rotates_shifts();
      test_bit_ops();
      test_unused_codes();
      test_carry_chains();
      test_random_mix(900);
      test_drain_pause();
      test_full_rate(240);

      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("words never returned", expected_results.size(), 0);

      codes_hit = 0;
      for (n = 0; n < 32; n++) if (cmd_seen[n] != 0) codes_hit++;
      $display("Sent %0d operation words and checked %0d result words.",
               words_sent, words_checked);
      $display("Covered %0d of 32 command codes, with stalls on both sides and a full drain.",
               codes_hit);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
sv/c8alu_pkg.sv
sv/c8alu_chan_if.sv
sv/c8alu_core.sv
sv/cpu8_alu_with_flags.sv
sv/c8alu_checker.sv
sim/cpu8_alu_with_flags_test.sv
